### hdl/assert_macros.svh
// Assertion macros used by the list engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define OALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OALE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/oale_pkg.sv
// Constants, codes and link types of the ordered array list engine.
package oale_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int SLOT_W     = 5;
  localparam int CMP_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_LOCATE = 2'd2,
    FN_SORTED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SLOT  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                         ins_en;
    logic                         del_en;
    logic                         srt_en;
    logic signed [DATA_WIDTH-1:0] word;
    logic [CMP_W-1:0]             slot;
    logic [CMP_W-1:0]             count;
  } cmd_t;

  // Upward locate scan carried from cell to cell.
  typedef struct packed {
    logic             seen;
    logic [IDX_W-1:0] found;
  } scan_t;

endpackage

### hdl/oale_cell.sv
// One slot of the list: holds an entry, shifts it and joins the search chains.
module oale_cell (
  input  logic                                  clk,
  input  oale_pkg::cmd_t                        cmd,
  input  logic [oale_pkg::CMP_W-1:0]            idx,
  input  logic signed [oale_pkg::DATA_WIDTH-1:0] left_val,
  input  logic signed [oale_pkg::DATA_WIDTH-1:0] right_val,
  input  logic                                  left_le,
  input  logic                                  le_above_in,
  input  oale_pkg::scan_t                       scan_in,
  output logic signed [oale_pkg::DATA_WIDTH-1:0] val,
  output logic                                  le,
  output logic                                  le_above_out,
  output oale_pkg::scan_t                       scan_out
);
  import oale_pkg::*;

  logic signed [DATA_WIDTH-1:0] elem_r;
  logic signed [DATA_WIDTH-1:0] elem_nxt;
  logic                         live;
  logic                         match;
  logic                         hit;
  logic                         ins_shift;
  logic                         ins_take;
  logic                         del_shift;
  logic                         srt_shift;
  logic                         srt_take;
  logic [CMP_W-1:0]             idx_inc;

  assign live         = idx < cmd.count;
  assign le           = live && !(elem_r > cmd.word);
  assign le_above_out = le_above_in | le;
  assign match        = live && (elem_r == cmd.word);
  assign hit          = match && !scan_in.seen;

  always_comb begin
    scan_out.seen  = scan_in.seen | match;
    scan_out.found = hit ? idx[IDX_W-1:0] : scan_in.found;
  end

  assign idx_inc   = idx + CMP_W'(1);
  assign ins_shift = cmd.ins_en && (idx > cmd.slot) && (idx <= cmd.count);
  assign ins_take  = cmd.ins_en && (idx == cmd.slot);
  assign del_shift = cmd.del_en && (idx >= cmd.slot) && (idx_inc < cmd.count);
  // Sorted insert lands just above the last entry not greater than the word.
  assign srt_shift = cmd.srt_en && (idx != '0) && (idx <= cmd.count) &&
                     !(left_le | le_above_out);
  assign srt_take  = cmd.srt_en && !le_above_out && ((idx == '0) || left_le);

  always_comb begin
    elem_nxt = elem_r;
    if (ins_take || srt_take) begin
      elem_nxt = cmd.word;
    end else if (ins_shift || srt_shift) begin
      elem_nxt = left_val;
    end else if (del_shift) begin
      elem_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign val = elem_r;

endmodule

### hdl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: command decode, cell row, result register.
//
//  Channel | Ports                                  | Direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_ready in_func in_value in_slot | into block
//  out     | out_valid out_ready out_status out_found_slot out_entries_now | out of block
//
// Each command completes at its transfer edge; the result is offered from the next cycle.
// A new command is taken each cycle while the result register is empty or being drained.
// The longest path is the compare chain through all CAPACITY cells.
// Synchronous reset empties the list; stored words are not cleared.
// A stalled result holds in_ready low until out_ready takes it.
module ordered_array_list_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic signed [31:0]              in_value,
  input  logic [oale_pkg::SLOT_W-1:0]     in_slot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [3:0]                      out_found_slot,
  output logic [4:0]                      out_entries_now
);
  import oale_pkg::*;

  `include "assert_macros.svh"

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  status_t          status_r;
  status_t          status_nxt;
  logic [3:0]       found_r;
  logic [3:0]       found_nxt;
  logic [4:0]       entries_r;

  logic             acc;
  func_t            func;
  logic [CMP_W-1:0] slot_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  cmd_t             cmd;

  logic signed [DATA_WIDTH-1:0] vals [CAPACITY];
  logic                         les [CAPACITY];
  logic                         le_above [CAPACITY+1];
  scan_t                        scan [CAPACITY+1];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign func     = func_t'(in_func);
  assign slot_c   = CMP_W'(in_slot);
  assign cnt_c    = CMP_W'(count_r);
  assign full     = count_r == CNT_W'(CAPACITY);

  always_comb begin
    cmd.ins_en = acc && (func == FN_INSERT) && !full && (slot_c <= cnt_c);
    cmd.del_en = acc && (func == FN_DELETE) && (slot_c < cnt_c);
    cmd.srt_en = acc && (func == FN_SORTED) && !full;
    cmd.word   = DATA_WIDTH'(in_value);
    cmd.slot   = slot_c;
    cmd.count  = cnt_c;
  end

  assign le_above[CAPACITY] = 1'b0;
  assign scan[0]            = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_v;
    logic signed [DATA_WIDTH-1:0] right_v;
    logic                         left_l;

    if (g == 0) begin : g_first
      assign left_v = vals[g];
      assign left_l = 1'b0;
    end else begin : g_inner
      assign left_v = vals[g-1];
      assign left_l = les[g-1];
    end

    // The top cell never takes from above: its neighbour value is its own.
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = vals[g];
    end else begin : g_lower
      assign right_v = vals[g+1];
    end

    oale_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .idx          (CMP_W'(g)),
      .left_val     (left_v),
      .right_val    (right_v),
      .left_le      (left_l),
      .le_above_in  (le_above[g+1]),
      .scan_in      (scan[g]),
      .val          (vals[g]),
      .le           (les[g]),
      .le_above_out (le_above[g]),
      .scan_out     (scan[g+1])
    );
  end

  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = '0;
    count_nxt  = count_r;
    case (func)
      FN_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (slot_c > cnt_c) begin
          status_nxt = ST_BAD_SLOT;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_DELETE: begin
        if (slot_c >= cnt_c) begin
          status_nxt = ST_BAD_SLOT;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_LOCATE: begin
        if (scan[CAPACITY].seen) begin
          found_nxt = 4'(scan[CAPACITY].found);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      FN_SORTED: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // Payload loads on every transfer in; no reset needed.
    if (acc) begin
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      entries_r <= 5'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_slot  = found_r;
  assign out_entries_now = entries_r;

  `OALE_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `OALE_ASSERT(a_result_follows, acc |=> out_valid_r, "transfer in without result")
  `OALE_ASSERT(a_full_means_cap, out_valid_r && status_r == ST_FULL |-> full,
               "full status with room left")
  `OALE_ASSERT(a_found_ok, out_valid_r && found_r != '0 |-> status_r == ST_OK,
               "found slot on failed command")
  `OALE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0) && !out_valid_r,
                      "reset did not empty the list")

endmodule

### bench/tb.sv
// Self-checking testbench for the ordered array list engine.
`timescale 1ns / 1ps

module tb;
  import oale_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    status_t    status;
    logic [3:0] found;
    logic [4:0] entries;
  } list_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FN_INSERT;
  logic signed [31:0] in_value = '0;
  logic [SLOT_W-1:0]  in_slot = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [3:0]         out_found_slot;
  logic [4:0]         out_entries_now;

  // Shadow copy of the list contents, slot 0 first.
  logic signed [31:0] list_q[$];
  list_result_t       pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;
  bit grow          = 1'b1;

  ordered_array_list_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_slot (out_found_slot),
    .out_entries_now(out_entries_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_cmd(func_t f, logic signed [31:0] v,
                                                  logic [SLOT_W-1:0] s);
    list_result_t r;
    int pos;
    r.status = ST_OK;
    r.found  = '0;
    case (f)
      FN_INSERT: begin
        if (list_q.size() >= CAPACITY) r.status = ST_FULL;
        else if (int'(s) > list_q.size()) r.status = ST_BAD_SLOT;
        else list_q.insert(int'(s), v);
      end
      FN_DELETE: begin
        if (int'(s) >= list_q.size()) r.status = ST_BAD_SLOT;
        else list_q.delete(int'(s));
      end
      FN_LOCATE: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < list_q.size(); i++) begin
          if (list_q[i] == v) begin
            r.status = ST_OK;
            r.found  = 4'(i);
            break;
          end
        end
      end
      default: begin
        if (list_q.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // Scan down from the last entry past every larger word.
          pos = list_q.size();
          while (pos > 0 && list_q[pos-1] > v) pos--;
          list_q.insert(pos, v);
        end
      end
    endcase
    r.entries = 5'(list_q.size());
    return r;
  endfunction

  // Offer one command and hold it until the transfer; valid stays high afterwards.
  task automatic send_cmd(input func_t f, input logic signed [31:0] v,
                          input logic [SLOT_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_value <= v;
    in_slot  <= s;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_cmd(f, v, s));
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return $signed(32'($urandom_range(8))) - 32'sd4;
    if (sel < 65 && list_q.size() > 0) return list_q[$urandom_range(list_q.size() - 1)];
    if (sel < 72) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return $signed($urandom);
  endfunction

  task automatic send_random_cmd();
    int    sel;
    int    cnt;
    func_t f;
    logic [SLOT_W-1:0] s;
    cnt = list_q.size();
    if (cnt == 0) grow = 1'b1;
    else if (cnt == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
    else if ($urandom_range(39) == 0) grow = ~grow;
    sel = $urandom_range(99);
    if (grow) f = (sel < 40) ? FN_INSERT : (sel < 55) ? FN_DELETE :
                  (sel < 75) ? FN_LOCATE : FN_SORTED;
    else      f = (sel < 15) ? FN_INSERT : (sel < 60) ? FN_DELETE :
                  (sel < 80) ? FN_LOCATE : FN_SORTED;
    if ($urandom_range(99) < 20) s = SLOT_W'($urandom_range(31));
    else if (f == FN_DELETE) s = SLOT_W'(cnt > 0 ? $urandom_range(cnt - 1) : 0);
    else s = SLOT_W'($urandom_range(cnt));
    send_cmd(f, pick_value(), s);
  endtask

  task automatic test_empty_list();
    send_cmd(FN_DELETE, 32'sd0, 5'd0);
    send_cmd(FN_LOCATE, 32'sd5, 5'd0);
    send_cmd(FN_INSERT, 32'sd1, 5'd1);
  endtask

  task automatic test_slot_edges();
    send_cmd(FN_INSERT, 32'sh7fffffff, 5'd0);
    send_cmd(FN_INSERT, 32'sh80000000, 5'd0);
    send_cmd(FN_INSERT, 32'sd0, 5'd2);
    send_cmd(FN_INSERT, -32'sd9, 5'd31);
    send_cmd(FN_SORTED, -32'sd1, 5'd31);
    send_cmd(FN_SORTED, 32'sd0, 5'd0);
    send_cmd(FN_LOCATE, 32'sd0, 5'd0);
    send_cmd(FN_LOCATE, 32'sd12345, 5'd0);
    send_cmd(FN_DELETE, 32'sd0, 5'd5);
    send_cmd(FN_DELETE, 32'sd0, 5'd2);
  endtask

  task automatic test_full_list();
    while (list_q.size() < CAPACITY)
      send_cmd(FN_SORTED, $signed(32'(list_q.size() * 1000 - 5000)), 5'd0);
    send_cmd(FN_INSERT, 32'sd7, 5'd31);
    send_cmd(FN_SORTED, 32'sd7, 5'd0);
    send_cmd(FN_LOCATE, list_q[CAPACITY-1], 5'd0);
  endtask

  // Stall the result side long enough for the input side to back up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req = 80;
    repeat (20) send_random_cmd();
    drain_results();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 19;
    recv_idle_pct = 65;
    repeat (550) send_random_cmd();
    send_idle_pct = 65;
    recv_idle_pct = 19;
    repeat (550) send_random_cmd();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (550) send_random_cmd();
    drain_results();
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d found=%0d entries=%0d", $time,
                 out_status, out_found_slot, out_entries_now);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_found_slot !== want.found) begin
          $display("%0t: found_slot expected %0d got %0d", $time, want.found,
                   out_found_slot);
          mismatches++;
        end
        if (out_entries_now !== want.entries) begin
          $display("%0t: entries_now expected %0d got %0d", $time, want.entries,
                   out_entries_now);
          mismatches++;
        end
      end
    end
  end

  // Abort when no transfer has happened on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 19;
    recv_idle_pct = 65;
    test_empty_list();
    test_slot_edges();
    test_full_list();
    drain_results();
    test_backpressure();
    test_random_traffic();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/oale_pkg.sv
hdl/oale_cell.sv
hdl/ordered_array_list_engine.sv
bench/tb.sv
